FILE: sv/vss_pkg.sv
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types and constants of the view stride solver.
// ----------------------------------------------------------------------------
package vss_pkg;

  localparam int unsigned DW    = 63;
  localparam int unsigned IDX_W = 3;

  localparam logic [1:0] ACT_SRC   = 2'd0;
  localparam logic [1:0] ACT_TGT   = 2'd1;
  localparam logic [1:0] ACT_SOLVE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOVIEW = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_NUMEL_MUL,
    OP_NUMEL_UPD,
    OP_ZERO_SETUP,
    OP_ZERO_MUL,
    OP_ZERO_UPD,
    OP_MAIN_SETUP,
    OP_T_ONE,
    OP_O_DEC,
    OP_N_DEC,
    OP_MATCH,
    OP_GRP_SETUP,
    OP_NC_MUL,
    OP_NC_UPD,
    OP_WANT_MUL,
    OP_OC_MUL,
    OP_OC_UPD,
    OP_FILL_DONE,
    OP_FILL_MUL,
    OP_FILL_UPD,
    OP_FIN,
    OP_EMIT
  } vss_op_e;

  typedef struct packed {
    vss_op_e    op;
    logic [1:0] st;
  } vss_cmd_t;

  typedef struct packed {
    logic oi_at_sc;
    logic numel_zero;
    logic tc_zero;
    logic ni_zero;
    logic oi_neg;
    logic ni_neg;
    logic ts_one;
    logic ss_one;
    logic ts_eq_ss;
    logic ni_at_top;
    logic nc_eq_oc;
    logic nc_lt_oc;
    logic mul_done;
    logic mul_ovf;
    logic want_eq;
    logic out_free;
    logic emit_last;
  } vss_stat_t;

endpackage

FILE: sv/vss_in_if.sv
// ----------------------------------------------------------------------------
// vss_in_if
// Input channel of the view stride solver: one dimension or command each.
// ----------------------------------------------------------------------------
interface vss_in_if import vss_pkg::*;;
  logic          valid;
  logic          ready;
  logic [1:0]    action;
  logic [DW-1:0] dim_size;
  logic [DW-1:0] dim_stride;

  modport source (output valid, action, dim_size, dim_stride, input ready);
  modport sink (input valid, action, dim_size, dim_stride, output ready);
endinterface

FILE: sv/vss_out_if.sv
// ----------------------------------------------------------------------------
// vss_out_if
// Output channel of the view stride solver: one solved stride each.
// ----------------------------------------------------------------------------
interface vss_out_if import vss_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] dim_index;
  logic [DW-1:0]    view_stride;
  logic [1:0]       status;
  logic             dim_valid;
  logic             last;

  modport source (output valid, dim_index, view_stride, status, dim_valid, last,
                  input ready);
  modport sink (input valid, dim_index, view_stride, status, dim_valid, last,
                output ready);
endinterface

FILE: sv/view_stride_solver.sv
// ----------------------------------------------------------------------------
// view_stride_solver
// Works out the strides of a reshaped view of a strided tensor.
// ----------------------------------------------------------------------------
// Usage: send source dimensions (action 0, size and stride, outermost first),
// then target sizes (action 1), then a solve command (action 2) on in_i.
// Appends beyond MAX_DIMS and action 3 are dropped. A load transaction is
// stored when accepted. A solve transaction returns one out_o transaction per
// target dimension, outermost first, with last set on the final one, or a
// single transaction with dim_valid low when the target rank is zero.
// The solve walk runs in a sequencer that shares one multiplier. It first
// forms the element count over the source dimensions, then settles matched
// and size-one dimensions directly and merges the other dimensions into
// groups, forming their products on the multiplier. Emission then gives one
// stride per cycle while the receiver is ready.
// in_i is not ready from a solve transaction until its last result has
// entered the output register. A stalled receiver holds that register and
// stops emission; loads resume once the last result is registered.
// After a solve, both dimension counts return to zero. Reset clears the
// counts and the output valid; stored dimensions are undefined until loaded.
// ----------------------------------------------------------------------------
module view_stride_solver import vss_pkg::*; #(
  parameter int unsigned MAX_DIMS = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vss_in_if.sink    in_i,
  vss_out_if.source out_o
);

  vss_cmd_t  cmd;
  vss_stat_t stat;

  vss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_action_i(in_i.action),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vss_dpath #(
    .MAX_DIMS(MAX_DIMS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_action_i      (in_i.action),
    .in_dim_size_i    (in_i.dim_size),
    .in_dim_stride_i  (in_i.dim_stride),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_dim_index_o  (out_o.dim_index),
    .out_view_stride_o(out_o.view_stride),
    .out_status_o     (out_o.status),
    .out_dim_valid_o  (out_o.dim_valid),
    .out_last_o       (out_o.last)
  );

endmodule

FILE: sv/vss_mul.sv
// ----------------------------------------------------------------------------
// vss_mul
// Multi-cycle 63 x 63 multiplier with overflow flag, 16 bits per cycle.
// ----------------------------------------------------------------------------
module vss_mul import vss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] prod_o,
  output logic          ovf_o
);

  logic [DW-1:0]  a_q;
  logic [63:0]    b_q, b_d;
  logic [127:0]   acc_q, acc_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [78:0]    pp;

  assign pp = {16'b0, a_q} * {63'b0, b_q[63:48]};

  always_comb begin
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      b_d    = {1'b0, b_i};
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      b_d   = {b_q[47:0], 16'b0};
      acc_d = {acc_q[111:0], 16'b0} + {49'b0, pp};
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q[DW-1:0];
  assign ovf_o  = |acc_q[127:DW];

endmodule

FILE: sv/vss_ctrl.sv
// ----------------------------------------------------------------------------
// vss_ctrl
// Sequencer of the view stride solver: loads, the solve walk and emission.
// ----------------------------------------------------------------------------
module vss_ctrl import vss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_action_i,
  output logic       in_ready_o,
  input  vss_stat_t  stat_i,
  output vss_cmd_t   cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_INIT  = 5'd1;
  localparam logic [4:0] S_NLOOP = 5'd2;
  localparam logic [4:0] S_NMUL  = 5'd3;
  localparam logic [4:0] S_NCHK  = 5'd4;
  localparam logic [4:0] S_ZLOOP = 5'd5;
  localparam logic [4:0] S_ZMUL  = 5'd6;
  localparam logic [4:0] S_MAIN  = 5'd7;
  localparam logic [4:0] S_SKIP  = 5'd8;
  localparam logic [4:0] S_GRP   = 5'd9;
  localparam logic [4:0] S_NCA   = 5'd10;
  localparam logic [4:0] S_NCM   = 5'd11;
  localparam logic [4:0] S_OSKIP = 5'd12;
  localparam logic [4:0] S_WM    = 5'd13;
  localparam logic [4:0] S_OM    = 5'd14;
  localparam logic [4:0] S_FILL  = 5'd15;
  localparam logic [4:0] S_FM    = 5'd16;
  localparam logic [4:0] S_TAIL  = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.st   = ST_OK;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          if (in_action_i == ACT_SOLVE) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_NLOOP;
      end
      S_NLOOP: begin
        if (stat_i.oi_at_sc) begin
          state_d = S_NCHK;
        end else begin
          cmd_o.op = OP_NUMEL_MUL;
          state_d  = S_NMUL;
        end
      end
      S_NMUL: begin
        if (stat_i.mul_done) begin
          if (stat_i.mul_ovf) begin
            cmd_o = '{op: OP_FIN, st: ST_OVF};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_NUMEL_UPD;
            state_d  = S_NLOOP;
          end
        end
      end
      S_NCHK: begin
        if (stat_i.numel_zero) begin
          if (stat_i.tc_zero) begin
            cmd_o = '{op: OP_FIN, st: ST_NOVIEW};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_ZERO_SETUP;
            state_d  = S_ZLOOP;
          end
        end else begin
          cmd_o.op = OP_MAIN_SETUP;
          state_d  = S_MAIN;
        end
      end
      S_ZLOOP: begin
        if (stat_i.ni_zero) begin
          cmd_o = '{op: OP_FIN, st: ST_OK};
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_ZERO_MUL;
          state_d  = S_ZMUL;
        end
      end
      S_ZMUL: begin
        if (stat_i.mul_done) begin
          if (stat_i.mul_ovf) begin
            cmd_o = '{op: OP_FIN, st: ST_OVF};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_ZERO_UPD;
            state_d  = S_ZLOOP;
          end
        end
      end
      S_MAIN: begin
        if (stat_i.oi_neg || stat_i.ni_neg) begin
          state_d = S_TAIL;
        end else if (stat_i.ts_one) begin
          cmd_o.op = OP_T_ONE;
        end else begin
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if (stat_i.oi_neg) begin
          cmd_o = '{op: OP_FIN, st: ST_NOVIEW};
          state_d = S_EMIT;
        end else if (stat_i.ss_one) begin
          cmd_o.op = OP_O_DEC;
        end else if (stat_i.ts_eq_ss) begin
          cmd_o.op = OP_MATCH;
          state_d  = S_MAIN;
        end else begin
          cmd_o.op = OP_GRP_SETUP;
          state_d  = S_GRP;
        end
      end
      S_GRP: begin
        if (stat_i.nc_eq_oc) begin
          state_d = S_FILL;
        end else if (stat_i.nc_lt_oc) begin
          cmd_o.op = OP_N_DEC;
          state_d  = S_NCA;
        end else begin
          cmd_o.op = OP_O_DEC;
          state_d  = S_OSKIP;
        end
      end
      S_NCA: begin
        if (stat_i.ni_neg) begin
          cmd_o = '{op: OP_FIN, st: ST_NOVIEW};
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_NC_MUL;
          state_d  = S_NCM;
        end
      end
      S_NCM: begin
        if (stat_i.mul_done) begin
          if (stat_i.mul_ovf) begin
            cmd_o = '{op: OP_FIN, st: ST_NOVIEW};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_NC_UPD;
            state_d  = S_GRP;
          end
        end
      end
      S_OSKIP: begin
        if (stat_i.oi_neg) begin
          cmd_o = '{op: OP_FIN, st: ST_NOVIEW};
          state_d = S_EMIT;
        end else if (stat_i.ss_one) begin
          cmd_o.op = OP_O_DEC;
        end else begin
          cmd_o.op = OP_WANT_MUL;
          state_d  = S_WM;
        end
      end
      S_WM: begin
        if (stat_i.mul_done) begin
          if (stat_i.mul_ovf || !stat_i.want_eq) begin
            cmd_o = '{op: OP_FIN, st: ST_NOVIEW};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_OC_MUL;
            state_d  = S_OM;
          end
        end
      end
      S_OM: begin
        if (stat_i.mul_done) begin
          if (stat_i.mul_ovf) begin
            cmd_o = '{op: OP_FIN, st: ST_OVF};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_OC_UPD;
            state_d  = S_GRP;
          end
        end
      end
      S_FILL: begin
        if (stat_i.ni_at_top) begin
          cmd_o.op = OP_FILL_DONE;
          state_d  = S_MAIN;
        end else begin
          cmd_o.op = OP_FILL_MUL;
          state_d  = S_FM;
        end
      end
      S_FM: begin
        if (stat_i.mul_done) begin
          if (stat_i.mul_ovf) begin
            cmd_o = '{op: OP_FIN, st: ST_OVF};
            state_d = S_EMIT;
          end else begin
            cmd_o.op = OP_FILL_UPD;
            state_d  = S_FILL;
          end
        end
      end
      S_TAIL: begin
        if (!stat_i.ni_neg) begin
          cmd_o.op = OP_T_ONE;
        end else if (!stat_i.oi_neg && stat_i.ss_one) begin
          cmd_o.op = OP_O_DEC;
        end else begin
          cmd_o.op = OP_FIN;
          cmd_o.st = stat_i.oi_neg ? ST_OK : ST_NOVIEW;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (stat_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/vss_dpath.sv
// ----------------------------------------------------------------------------
// vss_dpath
// Datapath of the view stride solver: dimension stores, walk indices,
// group products, the shared multiplier and the output register.
// ----------------------------------------------------------------------------
module vss_dpath import vss_pkg::*; #(
  parameter int unsigned MAX_DIMS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vss_cmd_t         cmd_i,
  output vss_stat_t        stat_o,
  input  logic [1:0]       in_action_i,
  input  logic [DW-1:0]    in_dim_size_i,
  input  logic [DW-1:0]    in_dim_stride_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] out_dim_index_o,
  output logic [DW-1:0]    out_view_stride_o,
  output logic [1:0]       out_status_o,
  output logic             out_dim_valid_o,
  output logic             out_last_o
);

  localparam int unsigned CW = $clog2(MAX_DIMS + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [DW-1:0] ss_q [MAX_DIMS];
  logic [DW-1:0] sst_q [MAX_DIMS];
  logic [DW-1:0] ts_q [MAX_DIMS];
  logic [DW-1:0] sv_q [MAX_DIMS];

  logic [CW-1:0]        sc_q, tc_q;
  logic signed [IW-1:0] oi_q, ni_q, top_q, bot_q;
  logic [DW-1:0]        numel_q, nc_q, oc_q, stride_q, psize_q, pstride_q;
  logic [1:0]           st_q;

  logic signed [IW-1:0] sc_s, tc_s, oi_m1, ni_m1, ni_p1, tc_m1;
  logic [DW-1:0]        ss_rd, sst_rd, ts_rd, sv_rd;
  logic                 mul_start, mul_done, mul_ovf;
  logic [DW-1:0]        mul_a, mul_b, mul_prod;
  logic                 emit_last, out_free;

  assign sc_s  = $signed({1'b0, sc_q});
  assign tc_s  = $signed({1'b0, tc_q});
  assign oi_m1 = oi_q - IW'(1);
  assign ni_m1 = ni_q - IW'(1);
  assign ni_p1 = ni_q + IW'(1);
  assign tc_m1 = tc_s - IW'(1);

  assign ss_rd  = ss_q[oi_q[AW-1:0]];
  assign sst_rd = sst_q[oi_q[AW-1:0]];
  assign ts_rd  = ts_q[ni_q[AW-1:0]];
  assign sv_rd  = sv_q[ni_q[AW-1:0]];

  assign emit_last = (tc_q == '0) || (ni_q == tc_m1);
  assign out_free  = !out_valid_o || out_ready_i;

  always_comb begin
    mul_start = 1'b1;
    mul_a     = numel_q;
    mul_b     = ss_rd;
    case (cmd_i.op)
      OP_NUMEL_MUL: begin
        mul_a = numel_q;
        mul_b = ss_rd;
      end
      OP_ZERO_MUL: begin
        mul_a = sv_rd;
        mul_b = ts_rd;
      end
      OP_NC_MUL: begin
        mul_a = nc_q;
        mul_b = ts_rd;
      end
      OP_WANT_MUL: begin
        mul_a = psize_q;
        mul_b = pstride_q;
      end
      OP_OC_MUL: begin
        mul_a = oc_q;
        mul_b = ss_rd;
      end
      OP_FILL_MUL: begin
        mul_a = stride_q;
        mul_b = ts_rd;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  vss_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod),
    .ovf_o  (mul_ovf)
  );

  always_comb begin
    stat_o.oi_at_sc   = (oi_q == sc_s);
    stat_o.numel_zero = (numel_q == '0);
    stat_o.tc_zero    = (tc_q == '0);
    stat_o.ni_zero    = (ni_q == '0);
    stat_o.oi_neg     = oi_q[IW-1];
    stat_o.ni_neg     = ni_q[IW-1];
    stat_o.ts_one     = (ts_rd == DW'(1));
    stat_o.ss_one     = (ss_rd == DW'(1));
    stat_o.ts_eq_ss   = (ts_rd == ss_rd);
    stat_o.ni_at_top  = (ni_q == top_q);
    stat_o.nc_eq_oc   = (nc_q == oc_q);
    stat_o.nc_lt_oc   = (nc_q < oc_q);
    stat_o.mul_done   = mul_done;
    stat_o.mul_ovf    = mul_ovf;
    stat_o.want_eq    = (mul_prod == sst_rd);
    stat_o.out_free   = out_free;
    stat_o.emit_last  = emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q        <= '0;
      tc_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.op == OP_EMIT) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          if (in_action_i == ACT_SRC && sc_q < CW'(MAX_DIMS)) begin
            sc_q <= sc_q + CW'(1);
          end
          if (in_action_i == ACT_TGT && tc_q < CW'(MAX_DIMS)) begin
            tc_q <= tc_q + CW'(1);
          end
        end
        OP_EMIT: begin
          if (emit_last) begin
            sc_q <= '0;
            tc_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        if (in_action_i == ACT_SRC && sc_q < CW'(MAX_DIMS)) begin
          ss_q[sc_q[AW-1:0]]  <= in_dim_size_i;
          sst_q[sc_q[AW-1:0]] <= in_dim_stride_i;
        end
        if (in_action_i == ACT_TGT && tc_q < CW'(MAX_DIMS)) begin
          ts_q[tc_q[AW-1:0]] <= in_dim_size_i;
        end
      end
      OP_INIT: begin
        numel_q <= DW'(1);
        oi_q    <= '0;
      end
      OP_NUMEL_UPD: begin
        numel_q <= mul_prod;
        oi_q    <= oi_q + IW'(1);
      end
      OP_ZERO_SETUP: begin
        sv_q[tc_m1[AW-1:0]] <= DW'(1);
        ni_q                <= tc_m1;
      end
      OP_ZERO_UPD: begin
        sv_q[ni_m1[AW-1:0]] <= mul_prod;
        ni_q                <= ni_m1;
      end
      OP_MAIN_SETUP: begin
        oi_q <= sc_s - IW'(1);
        ni_q <= tc_m1;
      end
      OP_T_ONE: begin
        sv_q[ni_q[AW-1:0]] <= '0;
        ni_q               <= ni_m1;
      end
      OP_O_DEC: begin
        oi_q <= oi_m1;
      end
      OP_N_DEC: begin
        ni_q  <= ni_m1;
        bot_q <= ni_m1;
      end
      OP_MATCH: begin
        sv_q[ni_q[AW-1:0]] <= sst_rd;
        ni_q               <= ni_m1;
        oi_q               <= oi_m1;
      end
      OP_GRP_SETUP: begin
        nc_q      <= ts_rd;
        oc_q      <= ss_rd;
        stride_q  <= sst_rd;
        top_q     <= ni_q;
        bot_q     <= ni_q;
        psize_q   <= ss_rd;
        pstride_q <= sst_rd;
      end
      OP_NC_UPD: begin
        nc_q <= mul_prod;
      end
      OP_OC_UPD: begin
        oc_q      <= mul_prod;
        psize_q   <= ss_rd;
        pstride_q <= sst_rd;
      end
      OP_FILL_DONE: begin
        sv_q[ni_q[AW-1:0]] <= stride_q;
        ni_q               <= bot_q - IW'(1);
        oi_q               <= oi_m1;
      end
      OP_FILL_MUL: begin
        sv_q[ni_q[AW-1:0]] <= stride_q;
      end
      OP_FILL_UPD: begin
        stride_q <= mul_prod;
        ni_q     <= ni_p1;
      end
      OP_FIN: begin
        st_q <= cmd_i.st;
        ni_q <= '0;
      end
      OP_EMIT: begin
        out_dim_index_o   <= (tc_q == '0) ? '0 : IDX_W'(ni_q);
        out_view_stride_o <= (st_q == ST_OK && tc_q != '0) ? sv_rd : '0;
        out_status_o      <= st_q;
        out_dim_valid_o   <= (tc_q != '0);
        out_last_o        <= emit_last;
        ni_q              <= ni_p1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/vss_checker.sv
// ----------------------------------------------------------------------------
// vss_checker
// Port-level checks of the view stride solver, bound to the top level.
// ----------------------------------------------------------------------------
module vss_checker import vss_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [IDX_W-1:0] out_dim_index_i,
  input logic [DW-1:0]    out_view_stride_i,
  input logic [1:0]       out_status_i,
  input logic             out_dim_valid_i,
  input logic             out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_view_stride_i)
      && $stable(out_status_i) && $stable(out_dim_index_i))
    else $error("Stalled result transaction changed.");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != ST_OK |-> out_view_stride_i == '0)
    else $error("Failed solve carried a nonzero stride.");

  a_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_dim_valid_i |-> out_last_i && out_dim_index_i == '0)
    else $error("Rank zero result was not a single final transaction.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == ST_OK || out_status_i == ST_NOVIEW
      || out_status_i == ST_OVF)
    else $error("Unknown status code.");

endmodule

bind view_stride_solver vss_checker u_vss_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_dim_index_i  (out_o.dim_index),
  .out_view_stride_i(out_o.view_stride),
  .out_status_i     (out_o.status),
  .out_dim_valid_i  (out_o.dim_valid),
  .out_last_i       (out_o.last)
);
